### src/cmwc_pkg.sv
`timescale 1ns / 1ps

package cmwc_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int WORD_W      = 32;
    localparam int CARRY_W     = 19;
    localparam int MULT_W      = 15;
    localparam int PROD_W      = WORD_W + MULT_W;
    localparam int T_W         = PROD_W + 1;
    localparam int HI_W        = T_W - WORD_W;

    localparam logic [WORD_W-1:0]  GOLDEN_PHI  = 32'h9e37_79b9;
    localparam logic [WORD_W-1:0]  GOLDEN_PHI2 = WORD_W'(64'(GOLDEN_PHI) * 64'd2);
    localparam logic [MULT_W-1:0]  CMWC_MULT   = 15'd18782;
    localparam logic [WORD_W-1:0]  CMWC_BASE   = 32'hffff_fffe;
    localparam logic [CARRY_W-1:0] CARRY_INIT  = 19'd362436;
    localparam logic [IDX_W-1:0]   LAST_INDEX  = IDX_W'(TABLE_DEPTH - 1);

    localparam logic CMD_SEED = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    typedef struct packed {
        logic [WORD_W-1:0] random_value;
        logic              seed_ack;
    } rsp_t;

endpackage

### src/cmwc_if.sv
`timescale 1ns / 1ps

interface cmwc_req_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [cmwc_pkg::WORD_W-1:0] seed_value;

    modport source (output valid, output command, output seed_value, input ready);
    modport sink   (input valid, input command, input seed_value, output ready);
endinterface

interface cmwc_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [cmwc_pkg::WORD_W-1:0] random_value;
    logic                        seed_ack;

    modport source (output valid, output random_value, output seed_ack, input ready);
    modport sink   (input valid, input random_value, input seed_ack, output ready);
endinterface

### src/cmwc_ram.sv
`timescale 1ns / 1ps

module cmwc_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### src/cmwc_out.sv
`timescale 1ns / 1ps

module cmwc_out (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  cmwc_pkg::rsp_t data,
    output logic          free,
    cmwc_rsp_if.source    rsp
);
    import cmwc_pkg::*;

    logic valid_reg;
    rsp_t data_reg;

    assign free             = !valid_reg || rsp.ready;
    assign rsp.valid        = valid_reg;
    assign rsp.random_value = data_reg.random_value;
    assign rsp.seed_ack     = data_reg.seed_ack;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && free)
        begin
            data_reg <= data;
        end
    end

    hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(data_reg)))
        else $error("response changed while stalled");

    no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("result loaded into a full output stage");

endmodule

### src/cmwc4096_random_generator.sv
`timescale 1ns / 1ps

// CMWC4096 random word generator. A request with command = 1 draws one 32-bit
// word; command = 0 reseeds the 4096-word lag table from seed_value and answers
// with seed_ack = 1 and a zero word. One request is processed at a time. A draw
// steps through S_RD (memory read), S_MUL (18782x multiply), S_ADD (carry add)
// and S_WB (end-around correction and write-back). A seed writes the table one
// word per cycle through the single memory port. The table needs no clearing
// pass after reset: until it has been fully written by a seed or by a full
// sweep of draws, table reads are taken as zero. A finished response waits in
// its own output register; the next request is taken as soon as the current
// one has been handed to it.
module cmwc4096_random_generator (
    input  logic       clk,
    input  logic       rst_n,
    cmwc_req_if.sink   req,
    cmwc_rsp_if.source rsp
);
    import cmwc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED,
        S_ACK,
        S_RD,
        S_MUL,
        S_ADD,
        S_WB
    } state_t;

    state_t              state_reg;
    logic [IDX_W-1:0]    pos_reg;
    logic [IDX_W-1:0]    pos_next;
    logic [IDX_W-1:0]    k_reg;
    logic [CARRY_W-1:0]  carry_reg;
    logic [CARRY_W-1:0]  carry_next;
    logic                live_reg;
    logic [WORD_W-1:0]   seed_reg;
    logic [WORD_W-1:0]   a0_reg;
    logic [WORD_W-1:0]   a1_reg;
    logic [WORD_W-1:0]   a2_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [T_W-1:0]      t_reg;

    logic                req_fire;
    logic                out_free;
    logic                out_load;
    rsp_t                out_data;
    logic                wb_fire;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_addr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [WORD_W-1:0]   ram_rdata;
    logic [WORD_W-1:0]   seed_word;
    logic [HI_W-1:0]     hi;
    logic [HI_W-1:0]     hi_fix;
    logic [WORD_W:0]     sum_ext;
    logic [WORD_W-1:0]   sum;
    logic [WORD_W-1:0]   draw_word;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign pos_next  = (pos_reg == LAST_INDEX) ? '0 : pos_reg + 1'b1;

    always_comb
    begin
        if (k_reg == IDX_W'(0))
        begin
            seed_word = seed_reg;
        end
        else if (k_reg == IDX_W'(1))
        begin
            seed_word = seed_reg + GOLDEN_PHI;
        end
        else if (k_reg == IDX_W'(2))
        begin
            seed_word = seed_reg + GOLDEN_PHI2;
        end
        else
        begin
            seed_word = a0_reg ^ a1_reg ^ GOLDEN_PHI ^ WORD_W'(k_reg);
        end
    end

    // end-around correction of the low word by the high half
    always_comb
    begin
        hi      = t_reg[T_W-1:WORD_W];
        sum_ext = {1'b0, t_reg[WORD_W-1:0]} + (WORD_W+1)'(hi);
        if (sum_ext[WORD_W])
        begin
            sum    = sum_ext[WORD_W-1:0] + 1'b1;
            hi_fix = hi + 1'b1;
        end
        else
        begin
            sum    = sum_ext[WORD_W-1:0];
            hi_fix = hi;
        end
        carry_next = CARRY_W'(hi_fix);
        draw_word  = CMWC_BASE - sum;
    end

    assign wb_fire   = (state_reg == S_WB) && out_free;
    assign ram_we    = (state_reg == S_SEED) || wb_fire;
    assign ram_addr  = (state_reg == S_SEED) ? k_reg : pos_reg;
    assign ram_wdata = (state_reg == S_SEED) ? seed_word : draw_word;

    assign out_load = wb_fire || ((state_reg == S_ACK) && out_free);
    always_comb
    begin
        out_data.random_value = (state_reg == S_WB) ? draw_word : '0;
        out_data.seed_ack     = (state_reg == S_ACK);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pos_reg   <= LAST_INDEX;
            carry_reg <= CARRY_INIT;
            live_reg  <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        seed_reg <= req.seed_value;
                        k_reg    <= '0;
                        if (req.command == CMD_DRAW)
                        begin
                            pos_reg   <= pos_next;
                            state_reg <= S_RD;
                        end
                        else
                        begin
                            state_reg <= S_SEED;
                        end
                    end
                end
                S_SEED:
                begin
                    a0_reg <= a1_reg;
                    a1_reg <= a2_reg;
                    a2_reg <= seed_word;
                    k_reg  <= k_reg + 1'b1;
                    if (k_reg == LAST_INDEX)
                    begin
                        live_reg  <= 1'b1;
                        state_reg <= S_ACK;
                    end
                end
                S_ACK:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    prod_reg  <= live_reg ? PROD_W'(ram_rdata) * PROD_W'(CMWC_MULT) : '0;
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    t_reg     <= T_W'(prod_reg) + T_W'(carry_reg);
                    state_reg <= S_WB;
                end
                S_WB:
                begin
                    if (out_free)
                    begin
                        carry_reg <= carry_next;
                        if (pos_reg == LAST_INDEX)
                        begin
                            live_reg <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    cmwc_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (WORD_W)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    cmwc_out u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (out_load),
        .data  (out_data),
        .free  (out_free),
        .rsp   (rsp)
    );

    carry_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        wb_fire |=> (carry_reg <= CARRY_W'(CMWC_MULT)))
        else $error("carry out of range after draw");

    seed_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req.command == CMD_SEED) |=> ($stable(pos_reg) && $stable(carry_reg)))
        else $error("seed request changed position or carry");

    ack_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_data.seed_ack) |-> live_reg)
        else $error("seed acknowledged before table fill");

    idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !out_load)
        else $error("result issued while idle");

endmodule
